[rtl/core/cau_pkg.sv]
// Shared types, constants and helpers for the complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

   localparam int FRAC_BITS = 8;
   localparam int PRE_W     = 34;
   localparam int DIV_W     = (33 + FRAC_BITS > 48) ? 33 + FRAC_BITS : 48;
   localparam int QUO_W     = 16;
   localparam int DIV_STEPS = QUO_W;

   localparam logic signed [PRE_W-1:0] SAT_MAX = PRE_W'(32767);
   localparam logic signed [PRE_W-1:0] SAT_MIN = -PRE_W'(32768);

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_CONJ = 3'd4,
      OP_CMP  = 3'd5
   } op_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [15:0] op_a_real;
      logic signed [15:0] op_a_imag;
      logic signed [15:0] op_b_real;
      logic signed [15:0] op_b_imag;
   } req_type;

   typedef struct packed {
      logic signed [15:0] result_real;
      logic signed [15:0] result_imag;
      logic               is_equal;
      logic               overflow;
      logic               divide_by_zero;
   } rsp_type;

   typedef struct packed {
      logic [2:0]              operation;
      logic signed [PRE_W-1:0] pre_re;
      logic signed [PRE_W-1:0] pre_im;
      logic                    eq;
      logic                    dz;
      logic                    neg_re;
      logic                    neg_im;
      logic                    big_re;
      logic                    big_im;
   } side_type;

   // {overflow, value}
   function automatic logic [16:0] sat16(input logic signed [PRE_W-1:0] v);
      logic [16:0] r;
      if (v > SAT_MAX) begin
         r = {1'b1, 16'h7fff};
      end else if (v < SAT_MIN) begin
         r = {1'b1, 16'h8000};
      end else begin
         r = {1'b0, v[15:0]};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/core/complex_arithmetic_unit.sv]
// Complex arithmetic unit top level: operand stages, divider chain, saturation.
// Fully pipelined complex ALU: one beat accepted per cycle unless the response
// side stalls; each result passes the input, product, sum, divide setup, 16
// divider steps and saturation stages. All operations share the same latency so
// results leave in order. A stall on the response side freezes the whole
// pipeline; req_ready follows !rsp_valid || rsp_ready.
`timescale 1ns / 1ps
`default_nettype none

module complex_arithmetic_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cau_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output cau_pkg::rsp_type      rsp_data
);
   import cau_pkg::*;

   localparam int PIPE_D = 4 + DIV_STEPS + 1;

   logic              en;
   logic [PIPE_D-1:0] vld_ff, vld_in;

   req_type            in_ff;
   side_type           sd2_ff, sd2_in, sd3_ff, sd3_in, sd4_ff, sd4_in;
   logic signed [31:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_r_ff, p_bb_i_ff;
   logic signed [32:0] num_re_ff, num_im_ff;
   logic [31:0]        den_ff;
   logic [DIV_W-1:0]   nre4_ff, nim4_ff, dsh4_ff;
   logic [32:0]        mag_re, mag_im;
   logic [DIV_W-1:0]   nre4_in, nim4_in;

   side_type           sd_ff [DIV_STEPS];
   logic [DIV_W-1:0]   rre_c [DIV_STEPS+1];
   logic [DIV_W-1:0]   rim_c [DIV_STEPS+1];
   logic [DIV_W-1:0]   dre_c [DIV_STEPS+1];
   logic [DIV_W-1:0]   dim_c [DIV_STEPS+1];
   logic [QUO_W-1:0]   qre_c [DIV_STEPS+1];
   logic [QUO_W-1:0]   qim_c [DIV_STEPS+1];

   side_type                sdl;
   logic signed [PRE_W-1:0] fre, fim;
   logic [16:0]             sre, sim;
   rsp_type                 rsp_ff, rsp_in;

   assign en        = !vld_ff[PIPE_D-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[PIPE_D-1];
   assign rsp_data  = rsp_ff;
   assign vld_in    = {vld_ff[PIPE_D-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // stage 2 side info: add, subtract, conjugate, compare
   always_comb begin
      sd2_in           = '0;
      sd2_in.operation = in_ff.operation;
      case (in_ff.operation)
         OP_ADD: begin
            sd2_in.pre_re = PRE_W'(in_ff.op_a_real) + PRE_W'(in_ff.op_b_real);
            sd2_in.pre_im = PRE_W'(in_ff.op_a_imag) + PRE_W'(in_ff.op_b_imag);
         end
         OP_SUB: begin
            sd2_in.pre_re = PRE_W'(in_ff.op_a_real) - PRE_W'(in_ff.op_b_real);
            sd2_in.pre_im = PRE_W'(in_ff.op_a_imag) - PRE_W'(in_ff.op_b_imag);
         end
         OP_CONJ: begin
            sd2_in.pre_re = PRE_W'(in_ff.op_a_real);
            sd2_in.pre_im = -PRE_W'(in_ff.op_a_imag);
         end
         OP_CMP: begin
            sd2_in.eq = (in_ff.op_a_real == in_ff.op_b_real) &&
                        (in_ff.op_a_imag == in_ff.op_b_imag);
         end
         default: begin
         end
      endcase
   end

   // stage 3: multiply result
   always_comb begin
      sd3_in = sd2_ff;
      if (sd2_ff.operation == OP_MUL) begin
         sd3_in.pre_re = (PRE_W'(p_rr_ff) - PRE_W'(p_ii_ff)) >>> FRAC_BITS;
         sd3_in.pre_im = (PRE_W'(p_ri_ff) + PRE_W'(p_ir_ff)) >>> FRAC_BITS;
      end
   end

   // stage 4: divide setup
   always_comb begin
      mag_re  = num_re_ff[32] ? 33'(-num_re_ff) : 33'(num_re_ff);
      mag_im  = num_im_ff[32] ? 33'(-num_im_ff) : 33'(num_im_ff);
      nre4_in = DIV_W'(mag_re) << FRAC_BITS;
      nim4_in = DIV_W'(mag_im) << FRAC_BITS;
      sd4_in        = sd3_ff;
      sd4_in.neg_re = num_re_ff[32];
      sd4_in.neg_im = num_im_ff[32];
      sd4_in.big_re = nre4_in >= (DIV_W'(den_ff) << QUO_W);
      sd4_in.big_im = nim4_in >= (DIV_W'(den_ff) << QUO_W);
      sd4_in.dz     = (sd3_ff.operation == OP_DIV) && (den_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff     <= req_data;
         p_rr_ff   <= in_ff.op_a_real * in_ff.op_b_real;
         p_ii_ff   <= in_ff.op_a_imag * in_ff.op_b_imag;
         p_ri_ff   <= in_ff.op_a_real * in_ff.op_b_imag;
         p_ir_ff   <= in_ff.op_a_imag * in_ff.op_b_real;
         p_bb_r_ff <= in_ff.op_b_real * in_ff.op_b_real;
         p_bb_i_ff <= in_ff.op_b_imag * in_ff.op_b_imag;
         sd2_ff    <= sd2_in;
         num_re_ff <= 33'(p_rr_ff) + 33'(p_ii_ff);
         num_im_ff <= 33'(p_ir_ff) - 33'(p_ri_ff);
         den_ff    <= $unsigned(p_bb_r_ff) + $unsigned(p_bb_i_ff);
         sd3_ff    <= sd3_in;
         nre4_ff   <= nre4_in;
         nim4_ff   <= nim4_in;
         dsh4_ff   <= DIV_W'(den_ff) << (QUO_W - 1);
         sd4_ff    <= sd4_in;
         sd_ff[0]  <= sd4_ff;
         for (int i = 1; i < DIV_STEPS; i++) begin
            sd_ff[i] <= sd_ff[i-1];
         end
         rsp_ff    <= rsp_in;
      end
   end

   assign rre_c[0] = nre4_ff;
   assign rim_c[0] = nim4_ff;
   assign dre_c[0] = dsh4_ff;
   assign dim_c[0] = dsh4_ff;
   assign qre_c[0] = '0;
   assign qim_c[0] = '0;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      cau_div_stage u_re (
         .clock  (clock),
         .en     (en),
         .rem_in (rre_c[k]),
         .dsh_in (dre_c[k]),
         .quo_in (qre_c[k]),
         .rem_ff (rre_c[k+1]),
         .dsh_ff (dre_c[k+1]),
         .quo_ff (qre_c[k+1])
      );
      cau_div_stage u_im (
         .clock  (clock),
         .en     (en),
         .rem_in (rim_c[k]),
         .dsh_in (dim_c[k]),
         .quo_in (qim_c[k]),
         .rem_ff (rim_c[k+1]),
         .dsh_ff (dim_c[k+1]),
         .quo_ff (qim_c[k+1])
      );
   end

   // final stage: pick divide quotient, saturate
   always_comb begin
      sdl = sd_ff[DIV_STEPS-1];
      fre = sdl.pre_re;
      fim = sdl.pre_im;
      if (sdl.operation == OP_DIV) begin
         if (sdl.dz) begin
            fre = '0;
            fim = '0;
         end else begin
            fre = sdl.big_re ? PRE_W'(33'sh10000) : PRE_W'(qre_c[DIV_STEPS]);
            fim = sdl.big_im ? PRE_W'(33'sh10000) : PRE_W'(qim_c[DIV_STEPS]);
            if (sdl.neg_re) fre = -fre;
            if (sdl.neg_im) fim = -fim;
         end
      end
      sre = sat16(fre);
      sim = sat16(fim);
      rsp_in.result_real    = sre[15:0];
      rsp_in.result_imag    = sim[15:0];
      rsp_in.is_equal       = sdl.eq;
      rsp_in.overflow       = sre[16] | sim[16];
      rsp_in.divide_by_zero = sdl.dz;
   end

`ifndef SYNTHESIS
   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |->
         !rsp_data.overflow && rsp_data.result_real == '0 && rsp_data.result_imag == '0)
      else $error("divide by zero beat carries data");
   a_eq_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_equal |->
         !rsp_data.overflow && !rsp_data.divide_by_zero && rsp_data.result_real == '0)
      else $error("compare beat carries data");
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

[rtl/core/cau_div_stage.sv]
// One restoring-division step: one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module cau_div_stage (
   input  wire logic                      clock,
   input  wire logic                      en,
   input  wire logic [cau_pkg::DIV_W-1:0] rem_in,
   input  wire logic [cau_pkg::DIV_W-1:0] dsh_in,
   input  wire logic [cau_pkg::QUO_W-1:0] quo_in,
   output logic      [cau_pkg::DIV_W-1:0] rem_ff,
   output logic      [cau_pkg::DIV_W-1:0] dsh_ff,
   output logic      [cau_pkg::QUO_W-1:0] quo_ff
);
   import cau_pkg::*;

   logic             ge;
   logic [DIV_W-1:0] rem_nx_in;

   assign ge        = rem_in >= dsh_in;
   assign rem_nx_in = ge ? rem_in - dsh_in : rem_in;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_nx_in;
         dsh_ff <= dsh_in >> 1;
         quo_ff <= {quo_in[QUO_W-2:0], ge};
      end
   end

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the complex arithmetic unit.
`timescale 1ns / 1ps

module testbench;
   import cau_pkg::*;

   localparam int NUM_RANDOM = 1530;
   localparam int LATENCY    = 21;

   typedef struct {
      op_type  op;
      int      ar, ai, br, bi;
      bit      has_gold;
      rsp_type gold;
   } vec_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_q[$];
   int      mismatches = 0;
   bit      stim_done = 1'b0;
   bit      hold_off = 1'b0;
   bit      calm = 1'b0;
   vec_type vecs[$];

   complex_arithmetic_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic logic signed [15:0] clamp(input longint v, inout bit ovf);
      if (v > 32767) begin
         ovf = 1'b1;
         return 16'sh7fff;
      end
      if (v < -32768) begin
         ovf = 1'b1;
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   function automatic rsp_type predict_result(input req_type r);
      rsp_type o;
      longint ar, ai, br, bi, re, im, den;
      bit ovf;
      ar = r.op_a_real; ai = r.op_a_imag; br = r.op_b_real; bi = r.op_b_imag;
      re = 0; im = 0; ovf = 0;
      o = '0;
      case (r.operation)
         OP_ADD: begin re = ar + br; im = ai + bi; end
         OP_SUB: begin re = ar - br; im = ai - bi; end
         OP_MUL: begin
            re = (ar * br - ai * bi) >>> FRAC_BITS;
            im = (ar * bi + ai * br) >>> FRAC_BITS;
         end
         OP_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) o.divide_by_zero = 1'b1;
            else begin
               re = ((ar * br + ai * bi) * (64'sd1 <<< FRAC_BITS)) / den;
               im = ((ai * br - ar * bi) * (64'sd1 <<< FRAC_BITS)) / den;
            end
         end
         OP_CONJ: begin re = ar; im = -ai; end
         OP_CMP: o.is_equal = (ar == br) && (ai == bi);
         default: ;
      endcase
      o.result_real = clamp(re, ovf);
      o.result_imag = clamp(im, ovf);
      o.overflow = ovf;
      return o;
   endfunction

   function automatic rsp_type mk(input int re, input int im, input bit eq, input bit ovf,
                                  input bit dz);
      rsp_type o;
      o.result_real = re[15:0];
      o.result_imag = im[15:0];
      o.is_equal = eq;
      o.overflow = ovf;
      o.divide_by_zero = dz;
      return o;
   endfunction

   function automatic void add_row(input op_type op, input int ar, input int ai, input int br,
                                   input int bi, input bit has_gold, input rsp_type gold);
      vec_type v;
      v.op = op; v.ar = ar; v.ai = ai; v.br = br; v.bi = bi;
      v.has_gold = has_gold; v.gold = gold;
      vecs.push_back(v);
   endfunction

   function automatic int rand_operand();
      case ($urandom_range(0, 5))
         0: return 32767;
         1: return -32768;
         2: return $urandom_range(0, 1024) - 512;
         3: return 0;
         default: return $urandom_range(0, 65535) - 32768;
      endcase
   endfunction

   task automatic send_beat(input req_type r);
      while (!calm && $urandom_range(0, 99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // record expectations at acceptance
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) expected_q.push_back(predict_result(req_data));
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %p", rsp_data);
         end else begin
            want = expected_q.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, rsp_data);
            end
         end
      end
   end

   // receiver
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         rsp_ready <= !hold_off && (calm || $urandom_range(0, 99) >= 36);
      end
   end

   // long receiver hold-off
   initial begin
      @(negedge reset);
      repeat (600) @(posedge clock);
      hold_off = 1'b1;
      repeat (80) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      req_type r;
      rsp_type gold;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      add_row(OP_ADD, 32767, 32767, 32767, -32768, 1, mk(32767, -1, 0, 1, 0));
      add_row(OP_ADD, -32768, 0, -32768, 0, 1, mk(-32768, 0, 0, 1, 0));
      add_row(OP_SUB, -32768, 32767, 1, -1, 1, mk(-32768, 32767, 0, 1, 0));
      add_row(OP_SUB, 256, 512, 256, 0, 1, mk(0, 512, 0, 0, 0));
      add_row(OP_MUL, 256, 0, 256, 0, 1, mk(256, 0, 0, 0, 0));
      add_row(OP_MUL, 32767, 32767, 32767, 32767, 0, gold);
      add_row(OP_MUL, -32768, -32768, -32768, 32767, 0, gold);
      add_row(OP_MUL, -1, 0, 1, 0, 1, mk(-1, 0, 0, 0, 0));
      add_row(OP_DIV, 1234, -55, 0, 0, 1, mk(0, 0, 0, 0, 1));
      add_row(OP_DIV, 256, 256, 256, 0, 1, mk(256, 256, 0, 0, 0));
      add_row(OP_DIV, 32767, -32768, 1, 0, 0, gold);
      add_row(OP_DIV, -32768, 32767, 0, -1, 0, gold);
      add_row(OP_DIV, -7, 3, 32767, -32768, 0, gold);
      add_row(OP_CONJ, 100, -32768, 0, 0, 1, mk(100, 32767, 0, 1, 0));
      add_row(OP_CONJ, -32768, 32767, 5, 5, 1, mk(-32768, -32767, 0, 0, 0));
      add_row(OP_CMP, 300, -300, 300, -300, 1, mk(0, 0, 1, 0, 0));
      add_row(OP_CMP, 300, -300, 300, -299, 1, mk(0, 0, 0, 0, 0));
      add_row(OP_CMP, -32768, 32767, -32768, 32767, 1, mk(0, 0, 1, 0, 0));
      add_row(op_type'(3'd6), 1, 2, 3, 4, 1, mk(0, 0, 0, 0, 0));
      add_row(op_type'(3'd7), -1, -1, -1, -1, 1, mk(0, 0, 0, 0, 0));

      foreach (vecs[i]) begin
         r.operation = vecs[i].op;
         r.op_a_real = vecs[i].ar[15:0];
         r.op_a_imag = vecs[i].ai[15:0];
         r.op_b_real = vecs[i].br[15:0];
         r.op_b_imag = vecs[i].bi[15:0];
         if (vecs[i].has_gold && predict_result(r) !== vecs[i].gold) begin
            mismatches++;
            if (mismatches <= 10)
               $display("table row %0d: expected %p predicted %p", i, vecs[i].gold,
                        predict_result(r));
         end
         send_beat(r);
      end

      for (int n = 0; n < NUM_RANDOM; n++) begin
         calm = (n >= 700 && n < 900);
         r.operation = $urandom_range(0, 99) < 3 ? 3'($urandom_range(6, 7))
                                                 : 3'($urandom_range(0, 5));
         r.op_a_real = 16'(rand_operand());
         r.op_a_imag = 16'(rand_operand());
         if (r.operation == OP_CMP && $urandom_range(0, 1)) begin
            r.op_b_real = r.op_a_real;
            r.op_b_imag = $urandom_range(0, 1) ? r.op_a_imag : 16'(rand_operand());
         end else begin
            r.op_b_real = 16'(rand_operand());
            r.op_b_imag = 16'(rand_operand());
         end
         send_beat(r);
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
